// ----- src/sacl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared codes, widths and types of the set-associative LRU tag store.
// ----------------------------------------------------------------------------
package sacl_pkg;

	localparam int ADDR_W    = 64;
	localparam int STAMP_W   = 32;
	localparam int CNT_W     = 32;
	localparam int WAY_IDX_W = 5;
	localparam int KIND_W    = 2;
	localparam int OUTC_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 5;
	localparam int OUT_BITS  = OUTC_W + 1 + 3 * CNT_W;
	localparam int OUT_DAT_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;
	localparam logic [KIND_W-1:0] KIND_IFETCH = 2'd3;

	localparam logic [OUTC_W-1:0] OUTC_HIT   = 2'd0;
	localparam logic [OUTC_W-1:0] OUTC_FILL  = 2'd1;
	localparam logic [OUTC_W-1:0] OUTC_EVICT = 2'd2;
	localparam logic [OUTC_W-1:0] OUTC_IGN   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

	typedef struct packed {
		logic                 hit;
		logic [WAY_IDX_W-1:0] hit_way;
		logic                 empty;
		logic [WAY_IDX_W-1:0] empty_way;
		logic [WAY_IDX_W-1:0] victim_way;
	} sel_t;

endpackage
`default_nettype wire

// ----- src/set_assoc_lru_cache_sim_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_unit
// Set-associative tag store with LRU replacement and saturating totals.
// ----------------------------------------------------------------------------
// Result: registered when the lookup of an accepted item finishes and the
// output is free. A new item is taken only once that lookup is done, as a
// read-modify-write of one set row in the single-port row memory (read at accept, write at lookup).
// Reset: counters and per-set row-valid flops cleared at once, config set to
// one set, no offset, one way; no clearing pass, items accepted right after reset.
module set_assoc_lru_cache_sim_unit #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [sacl_pkg::ADDR_W-1:0]        s_tdata,  // address
	input  wire logic [sacl_pkg::KIND_W-1:0]        s_tuser,  // kind
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// outcome, extra_hit, hit_total, miss_total, evict_total, zero pad
	output logic [sacl_pkg::OUT_DAT_W-1:0]          m_tdata,
	input  wire logic                               cfg_we,
	input  wire logic [sacl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sacl_pkg::CFG_DAT_W-1:0]     cfg_data
);
	import sacl_pkg::*;

	localparam int ROWS   = 1 << MAX_SET_BITS;
	localparam int SET_IW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W = $clog2(MAX_WAYS + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LOOK = 1'b1;

	typedef struct packed {
		logic [MAX_WAYS-1:0]              valid;
		logic [MAX_WAYS-1:0][ADDR_W-1:0]  tag;
		logic [MAX_WAYS-1:0][STAMP_W-1:0] stamp;
	} row_t;

	logic                 state_q;
	logic [2:0]           set_bits_q;
	logic [4:0]           block_bits_q;
	logic [3:0]           ways_used_q;
	logic [STAMP_W-1:0]   use_clock_q;
	logic [CNT_W-1:0]     hits_q;
	logic [CNT_W-1:0]     misses_q;
	logic [CNT_W-1:0]     evicts_q;
	logic [ROWS-1:0]      row_ok_q;
	logic                 m_tvalid_q;
	logic [OUT_DAT_W-1:0] m_tdata_q;

	logic [ADDR_W-1:0]    tag_s1;
	logic [SET_IW-1:0]    set_s1;
	logic [KIND_W-1:0]    kind_s1;

	row_t                 mem [ROWS];
	row_t                 rdata_q;

	logic                 accept;
	logic                 done;
	logic [2:0]           sb;
	logic [5:0]           shamt;
	logic [ADDR_W-1:0]    addr_blk;
	logic [SET_IW-1:0]    set_mask;
	logic [SET_IW-1:0]    set_in;
	logic [WCNT_W-1:0]    ways_eff;
	row_t                 row_rd;
	row_t                 row_wr;
	sel_t                 sel;
	logic [WAY_W-1:0]     slot;
	logic                 active;
	logic [CNT_W:0]       hit_sum;
	logic [1:0]           hit_inc;
	logic [CNT_W-1:0]     hits_nx;
	logic [CNT_W-1:0]     misses_nx;
	logic [CNT_W-1:0]     evicts_nx;
	logic [OUTC_W-1:0]    outc;
	logic                 extra;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign done     = (state_q == ST_LOOK) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// address split
	assign sb       = (int'(set_bits_q) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_q;
	assign shamt    = {1'b0, block_bits_q} + {3'b000, sb};
	assign addr_blk = s_tdata >> block_bits_q;
	assign set_mask = SET_IW'((8'd1 << sb) - 8'd1);
	assign set_in   = addr_blk[SET_IW-1:0] & set_mask;

	always_comb begin
		if (ways_used_q == 4'd0) begin
			ways_eff = WCNT_W'(1);
		end else if (int'(ways_used_q) > MAX_WAYS) begin
			ways_eff = WCNT_W'(MAX_WAYS);
		end else begin
			ways_eff = WCNT_W'(ways_used_q);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q <= mem[set_in];
			tag_s1  <= s_tdata >> shamt;
			set_s1  <= set_in;
			kind_s1 <= s_tuser;
		end
		if (done && active) begin
			mem[set_s1] <= row_wr;
		end
	end

	always_comb begin
		row_rd       = rdata_q;
		row_rd.valid = row_ok_q[set_s1] ? rdata_q.valid : '0;
	end

	sacl_way_sel #(
		.MAX_WAYS (MAX_WAYS),
		.WCNT_W   (WCNT_W)
	) u_way_sel (
		.valid     (row_rd.valid),
		.tags      (row_rd.tag),
		.stamps    (row_rd.stamp),
		.tag       (tag_s1),
		.use_clock (use_clock_q),
		.ways_eff  (ways_eff),
		.sel       (sel)
	);

	assign active = (kind_s1 != KIND_IFETCH);

	always_comb begin
		if (sel.hit) begin
			slot = sel.hit_way[WAY_W-1:0];
		end else if (sel.empty) begin
			slot = sel.empty_way[WAY_W-1:0];
		end else begin
			slot = sel.victim_way[WAY_W-1:0];
		end
		row_wr             = row_rd;
		row_wr.stamp[slot] = use_clock_q;
		if (!sel.hit) begin
			row_wr.valid[slot] = 1'b1;
			row_wr.tag[slot]   = tag_s1;
		end
	end

	always_comb begin
		outc      = OUTC_IGN;
		extra     = 1'b0;
		hit_inc   = 2'd0;
		misses_nx = misses_q;
		evicts_nx = evicts_q;
		if (active) begin
			extra = (kind_s1 == KIND_MODIFY);
			if (sel.hit) begin
				outc = OUTC_HIT;
			end else begin
				outc      = sel.empty ? OUTC_FILL : OUTC_EVICT;
				misses_nx = (&misses_q) ? misses_q : misses_q + CNT_W'(1);
				if (!sel.empty) begin
					evicts_nx = (&evicts_q) ? evicts_q : evicts_q + CNT_W'(1);
				end
			end
			hit_inc = {1'b0, sel.hit} + {1'b0, extra};
		end
		hit_sum = {1'b0, hits_q} + {{(CNT_W - 1){1'b0}}, hit_inc};
		hits_nx = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			set_bits_q   <= 3'd0;
			block_bits_q <= 5'd0;
			ways_used_q  <= 4'd1;
			use_clock_q  <= '0;
			hits_q       <= '0;
			misses_q     <= '0;
			evicts_q     <= '0;
			row_ok_q     <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SET_BITS:   set_bits_q   <= cfg_data[2:0];
					CFG_BLOCK_BITS: block_bits_q <= cfg_data;
					CFG_WAYS_USED:  ways_used_q  <= cfg_data[3:0];
					default:        ;
				endcase
			end
			if (done) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (done) begin
						state_q    <= ST_IDLE;
						hits_q     <= hits_nx;
						misses_q   <= misses_nx;
						evicts_q   <= evicts_nx;
						if (active) begin
							use_clock_q      <= use_clock_q + STAMP_W'(1);
							row_ok_q[set_s1] <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_tdata_q <= OUT_DAT_W'({evicts_nx, misses_nx, hits_nx, extra, outc});
		end
	end

`ifndef SYNTHESIS
	a_accept_to_look: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_LOOK))
		else $error("accepted item did not enter lookup");

	a_done_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> m_tvalid_q)
		else $error("finished lookup did not present a result");

	a_clock_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(done) |-> $stable(use_clock_q))
		else $error("use clock moved without a finished access");

	a_hits_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> (hits_q >= $past(hits_q)))
		else $error("hit total decreased");

	a_hit_not_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(done && active && sel.hit) |=> (m_tdata_q[OUTC_W-1:0] == OUTC_HIT))
		else $error("hit not reported as hit");
`endif

endmodule
`default_nettype wire

// ----- src/sacl_way_sel.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_way_sel
// Compares the ways in use of one set row: lowest hit way, first empty way, LRU victim.
// ----------------------------------------------------------------------------
module sacl_way_sel #(
	parameter int MAX_WAYS = 8,
	parameter int WCNT_W   = $clog2(MAX_WAYS + 1)
) (
	input  wire logic [MAX_WAYS-1:0]                       valid,
	input  wire logic [MAX_WAYS-1:0][sacl_pkg::ADDR_W-1:0]  tags,
	input  wire logic [MAX_WAYS-1:0][sacl_pkg::STAMP_W-1:0] stamps,
	input  wire logic [sacl_pkg::ADDR_W-1:0]                tag,
	input  wire logic [sacl_pkg::STAMP_W-1:0]               use_clock,
	input  wire logic [WCNT_W-1:0]                          ways_eff,
	output sacl_pkg::sel_t                                  sel
);
	import sacl_pkg::*;

	logic [MAX_WAYS-1:0]              in_use;
	logic [MAX_WAYS-1:0]              match;
	logic [MAX_WAYS-1:0][STAMP_W-1:0] age;

	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			in_use[w] = (w < int'(ways_eff));
			match[w]  = in_use[w] && valid[w] && (tags[w] == tag);
			age[w]    = use_clock - stamps[w];
		end
	end

	always_comb begin
		logic               have;
		logic [STAMP_W-1:0] oldest;
		have   = 1'b0;
		oldest = '0;
		sel    = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				sel.hit     = 1'b1;
				sel.hit_way = WAY_IDX_W'(w);
			end
			if (in_use[w] && !valid[w]) begin
				sel.empty     = 1'b1;
				sel.empty_way = WAY_IDX_W'(w);
			end
		end
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (in_use[w] && valid[w] && !match[w] && (!have || age[w] > oldest)) begin
				have           = 1'b1;
				oldest         = age[w];
				sel.victim_way = WAY_IDX_W'(w);
			end
		end
	end

endmodule
`default_nettype wire

// ----- tb/set_assoc_lru_cache_sim_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_unit_tb
// Self-checking bench for the set-associative LRU tag store. A clocked driver
// feeds access items from a queue, a clocked monitor compares every result
// with a cache tag model kept inside the bench, and the initial block steps
// through register settings between directed and random access phases.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_unit_tb;
	import sacl_pkg::*;

	localparam int WAYS_MAX    = 8;
	localparam int SETBITS_MAX = 6;
	localparam int LINES       = (1 << SETBITS_MAX) * WAYS_MAX;
	localparam int IDLE_LIMIT  = 5000;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] addr;
	} access_t;

	typedef struct {
		logic [OUTC_W-1:0] outcome;
		logic              extra;
		logic [CNT_W-1:0]  hits;
		logic [CNT_W-1:0]  misses;
		logic [CNT_W-1:0]  evicts;
	} tally_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [ADDR_W-1:0]    s_tdata   = '0;  // address
	logic [KIND_W-1:0]    s_tuser   = KIND_LOAD;  // kind
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	// outcome, extra_hit, hit_total, miss_total, evict_total, zero pad
	logic [OUT_DAT_W-1:0] m_tdata;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SET_BITS;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;

	set_assoc_lru_cache_sim_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// cache model state
	bit               line_ok  [LINES];
	logic [63:0]      line_tag [LINES];
	logic [31:0]      line_age [LINES];
	logic [31:0]      age_clock = '0;
	logic [31:0]      hit_cnt   = '0;
	logic [31:0]      miss_cnt  = '0;
	logic [31:0]      evict_cnt = '0;
	logic [2:0]       set_bits_r   = 3'd0;
	logic [4:0]       block_bits_r = 5'd0;
	logic [3:0]       ways_r       = 4'd1;

	access_t pending_q[$];
	tally_t  tally_q[$];
	int      queued_cnt = 0;
	int      sent_cnt   = 0;
	int      fails      = 0;
	bit      burst_mode = 1'b0;

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic int eff_set_bits();
		return (set_bits_r > SETBITS_MAX) ? SETBITS_MAX : int'(set_bits_r);
	endfunction

	function automatic int eff_ways();
		if (ways_r == 0)
			return 1;
		return (ways_r > WAYS_MAX) ? WAYS_MAX : int'(ways_r);
	endfunction

	function automatic tally_t cache_access(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr);
		tally_t      r;
		int          sb;
		int          nways;
		int          set_idx;
		int          base;
		int          hit_way;
		int          empty_way;
		int          victim;
		int          slot;
		bit          have_victim;
		logic [63:0] tag;
		logic [31:0] age;
		logic [31:0] oldest;
		r.outcome = OUTC_IGN;
		r.extra   = 1'b0;
		if (kind != KIND_IFETCH) begin
			sb          = eff_set_bits();
			nways       = eff_ways();
			tag         = addr >> (int'(block_bits_r) + sb);
			set_idx     = int'((addr >> block_bits_r) & ((64'd1 << sb) - 64'd1));
			base        = set_idx * WAYS_MAX;
			hit_way     = -1;
			empty_way   = -1;
			victim      = 0;
			oldest      = '0;
			have_victim = 1'b0;
			for (int w = 0; w < nways; w++) begin
				if (line_ok[base + w]) begin
					if (line_tag[base + w] == tag) begin
						if (hit_way < 0)
							hit_way = w;
					end else begin
						age = age_clock - line_age[base + w];
						if (!have_victim || age > oldest) begin
							oldest      = age;
							victim      = w;
							have_victim = 1'b1;
						end
					end
				end else if (empty_way < 0) begin
					empty_way = w;
				end
			end
			if (hit_way >= 0) begin
				line_age[base + hit_way] = age_clock;
				hit_cnt   = sat_inc(hit_cnt);
				r.outcome = OUTC_HIT;
			end else begin
				miss_cnt = sat_inc(miss_cnt);
				if (empty_way >= 0) begin
					slot      = base + empty_way;
					r.outcome = OUTC_FILL;
				end else begin
					slot      = base + victim;
					evict_cnt = sat_inc(evict_cnt);
					r.outcome = OUTC_EVICT;
				end
				line_ok[slot]  = 1'b1;
				line_tag[slot] = tag;
				line_age[slot] = age_clock;
			end
			age_clock = age_clock + 32'd1;
			if (kind == KIND_MODIFY) begin
				hit_cnt = sat_inc(hit_cnt);
				r.extra = 1'b1;
			end
		end
		r.hits   = hit_cnt;
		r.misses = miss_cnt;
		r.evicts = evict_cnt;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (burst_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// driver
	int      in_gap = 0;
	access_t cur_item;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= KIND_LOAD;
			in_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				tally_q.push_back(cache_access(cur_item.kind, cur_item.addr));
				sent_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (in_gap > 0) begin
					in_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					cur_item = pending_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= cur_item.addr;
					s_tuser  <= cur_item.kind;
					in_gap = pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int     out_stall = 0;
	tally_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			out_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (tally_q.size() == 0) begin
					$error("result with no access pending: %h", m_tdata);
					fails++;
				end else begin
					want = tally_q.pop_front();
					if (m_tdata[1:0] !== want.outcome) begin
						$error("outcome: expected %0d, got %0d", want.outcome, m_tdata[1:0]);
						fails++;
					end
					if (m_tdata[2] !== want.extra) begin
						$error("extra_hit: expected %0d, got %0d", want.extra, m_tdata[2]);
						fails++;
					end
					if (m_tdata[34:3] !== want.hits) begin
						$error("hit_total: expected %0d, got %0d", want.hits, m_tdata[34:3]);
						fails++;
					end
					if (m_tdata[66:35] !== want.misses) begin
						$error("miss_total: expected %0d, got %0d", want.misses,
							m_tdata[66:35]);
						fails++;
					end
					if (m_tdata[98:67] !== want.evicts) begin
						$error("evict_total: expected %0d, got %0d", want.evicts,
							m_tdata[98:67]);
						fails++;
					end
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				m_tready <= 1'b0;
			end else if (burst_mode || $urandom_range(0, 99) < 70) begin
				m_tready <= 1'b1;
			end else begin
				out_stall = pick_gap();
				m_tready <= 1'b0;
			end
		end
	end

	// watchdog
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("set_assoc_lru_cache_sim_unit verification failed");
				$finish;
			end
		end
	end

	task automatic send(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr);
		access_t a;
		a.kind = kind;
		a.addr = addr;
		pending_q.push_back(a);
		queued_cnt++;
	endtask

	task automatic drain();
		while (sent_cnt != queued_cnt || tally_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_SET_BITS:   set_bits_r   = val[2:0];
			CFG_BLOCK_BITS: block_bits_r = val[4:0];
			CFG_WAYS_USED:  ways_r       = val[3:0];
			default: ;
		endcase
	endtask

	task automatic cfg_done();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(int sb, int bb, int wy);
		drain();
		cfg_write(CFG_SET_BITS, CFG_DAT_W'(sb));
		cfg_write(CFG_BLOCK_BITS, CFG_DAT_W'(bb));
		cfg_write(CFG_WAYS_USED, CFG_DAT_W'(wy));
		cfg_done();
	endtask

	task automatic set_ways(int wy);
		drain();
		cfg_write(CFG_WAYS_USED, CFG_DAT_W'(wy));
		cfg_done();
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic random_phase(int count);
		logic [63:0] tags[$];
		logic [63:0] offs;
		logic [63:0] addr;
		int          sb;
		int          bb;
		int          nsets;
		int          set_idx;
		int          r;
		sb    = eff_set_bits();
		bb    = int'(block_bits_r);
		nsets = 1 << sb;
		if (nsets > 4)
			nsets = 4;
		tags.delete();
		repeat (eff_ways() + $urandom_range(1, 4))
			tags.push_back(rand64());
		burst_mode = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				send(KIND_IFETCH, rand64());
			end else if (r < 20) begin
				send(KIND_W'($urandom_range(0, 2)), rand64());
			end else begin
				set_idx = $urandom_range(0, nsets - 1);
				offs    = rand64() & ((64'd1 << bb) - 64'd1);
				addr    = (tags[$urandom_range(0, tags.size() - 1)] << (bb + sb))
					| (64'(set_idx) << bb) | offs;
				send(KIND_W'($urandom_range(0, 2)), addr);
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset configuration: one set, no offset, one way
		send(KIND_LOAD, 64'h0);
		send(KIND_LOAD, 64'h0);
		send(KIND_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
		send(KIND_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
		send(KIND_IFETCH, 64'h0);
		send(KIND_MODIFY, 64'h1);
		send(KIND_LOAD, 64'h0);

		// out-of-range register values and widest shift
		set_config(7, 31, 0);
		send(KIND_LOAD, 64'h8000_0000_0000_0000);
		send(KIND_LOAD, 64'h0000_0000_7FFF_FFFF);
		send(KIND_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
		send(KIND_IFETCH, 64'hFFFF_FFFF_FFFF_FFFF);

		// duplicate tags left in a hidden way, then lowest way wins
		set_config(2, 4, 1);
		send(KIND_LOAD, 64'h0000_0000_0000_0510);
		set_ways(2);
		send(KIND_LOAD, 64'h0000_0000_0000_0A10);
		set_ways(1);
		send(KIND_LOAD, 64'h0000_0000_0000_0A10);
		set_ways(2);
		send(KIND_LOAD, 64'h0000_0000_0000_0A10);
		send(KIND_MODIFY, 64'h0000_0000_0000_0510);
		send(KIND_LOAD, 64'h0000_0000_0000_0A1F);

		set_config(6, 16, 8);
		random_phase(150);
		set_config(7, 0, 15);
		random_phase(150);
		set_config(0, 31, 0);
		random_phase(150);
		set_config(0, 0, 8);
		random_phase(150);
		for (int p = 0; p < 9; p++) begin
			set_config($urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 15));
			random_phase(150);
		end

		drain();
		repeat (8) @(posedge clk);
		if (fails == 0 && tally_q.size() == 0)
			$display("set_assoc_lru_cache_sim_unit verification clean");
		else
			$display("set_assoc_lru_cache_sim_unit verification failed");
		$finish;
	end

endmodule

// ----- set_assoc_lru_cache_sim_unit.f -----
src/sacl_pkg.sv
src/sacl_way_sel.sv
src/set_assoc_lru_cache_sim_unit.sv
tb/set_assoc_lru_cache_sim_unit_tb.sv
